// ===== rtl/sat_pkg.sv =====
// Shared widths, types and codes for the rectangle separating-axis test.
package sat_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int AXIS_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = COORD_WIDTH + AXIS_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_POINTS  = 2 * NUM_CORNERS;
  localparam int NUM_LANES   = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  typedef enum logic {
    ROLE_SELF   = 1'b0,
    ROLE_TARGET = 1'b1
  } role_e;

  // Projected intervals of both shapes on one axis.
  typedef struct packed {
    sum_t smin;
    sum_t smax;
    sum_t tmin;
    sum_t tmax;
  } sat_span_t;

  // Stage enables handed from the top level to the lanes.
  typedef struct packed {
    logic en_prod;
    logic en_sum;
    logic en_span;
  } sat_pipe_ctrl_t;

endpackage

// ===== rtl/rect_separating_axis_test.sv =====
// Top level of the rectangle separating-axis overlap test.
//
//   Channel | Signals                                   | Direction
//   input   | in_valid_i, in_stall_o, role_i, corner*_i | into the block
//   output  | out_valid_o, out_stall_i, overlap_o       | out of the block
//
// One item is taken per cycle while in_stall_o is low. A self item updates the stored shape at
// its transfer and makes no result. A target item passes through the axis registers, product
// registers, sum registers, interval registers in the four axis lanes, then the merge
// register.
// Reset clears the stored self shape to all zero and empties the pipeline.
// Empty stages close up behind a stalled output; in_stall_o rises only when every
// stage holds a target item and the output is stalled.
module rect_separating_axis_test import sat_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   role_i,
  input  coord_t corner0_x_i,
  input  coord_t corner0_y_i,
  input  coord_t corner1_x_i,
  input  coord_t corner1_y_i,
  input  coord_t corner2_x_i,
  input  coord_t corner2_y_i,
  input  coord_t corner3_x_i,
  input  coord_t corner3_y_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output logic   overlap_o
);

  coord_t in_x [NUM_CORNERS];
  coord_t in_y [NUM_CORNERS];

  assign in_x[0] = corner0_x_i;
  assign in_y[0] = corner0_y_i;
  assign in_x[1] = corner1_x_i;
  assign in_y[1] = corner1_y_i;
  assign in_x[2] = corner2_x_i;
  assign in_y[2] = corner2_y_i;
  assign in_x[3] = corner3_x_i;
  assign in_y[3] = corner3_y_i;

  // Pipeline control.
  logic           v1_q, v2_q, v3_q, v4_q, vout_q;
  logic           en1, en2, en3, en4, en5;
  logic           in_xfer, self_xfer, tgt_xfer;
  sat_pipe_ctrl_t pipe_ctrl;

  assign en5 = !vout_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;
  assign in_xfer    = in_valid_i && en1;
  assign self_xfer  = in_xfer && (role_i == ROLE_SELF);
  assign tgt_xfer   = in_xfer && (role_i == ROLE_TARGET);

  assign pipe_ctrl.en_prod = en2;
  assign pipe_ctrl.en_sum  = en3;
  assign pipe_ctrl.en_span = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (en1) v1_q   <= tgt_xfer;
      if (en2) v2_q   <= v1_q;
      if (en3) v3_q   <= v2_q;
      if (en4) v4_q   <= v3_q;
      if (en5) vout_q <= v4_q;
    end
  end

  // Stored self shape with both of its edge axes, kept ready for later targets.
  coord_t self_x_q [NUM_CORNERS];
  coord_t self_y_q [NUM_CORNERS];
  axis_t  self_ax_q [2];
  axis_t  self_ay_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        self_x_q[k] <= '0;
        self_y_q[k] <= '0;
      end
      for (int k = 0; k < 2; k++) begin
        self_ax_q[k] <= '0;
        self_ay_q[k] <= '0;
      end
    end else if (self_xfer) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        self_x_q[k] <= in_x[k];
        self_y_q[k] <= in_y[k];
      end
      self_ax_q[0] <= AXIS_WIDTH'(in_x[1]) - AXIS_WIDTH'(in_x[0]);
      self_ay_q[0] <= AXIS_WIDTH'(in_y[1]) - AXIS_WIDTH'(in_y[0]);
      self_ax_q[1] <= AXIS_WIDTH'(in_x[1]) - AXIS_WIDTH'(in_x[2]);
      self_ay_q[1] <= AXIS_WIDTH'(in_y[1]) - AXIS_WIDTH'(in_y[2]);
    end
  end

  // Stage 1: the target, a snapshot of the self shape and all four axes.
  coord_t s1_x_q [NUM_CORNERS];
  coord_t s1_y_q [NUM_CORNERS];
  coord_t t1_x_q [NUM_CORNERS];
  coord_t t1_y_q [NUM_CORNERS];
  axis_t  ax1_q [NUM_LANES];
  axis_t  ay1_q [NUM_LANES];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        s1_x_q[k] <= self_x_q[k];
        s1_y_q[k] <= self_y_q[k];
        t1_x_q[k] <= in_x[k];
        t1_y_q[k] <= in_y[k];
      end
      ax1_q[0] <= self_ax_q[0];
      ay1_q[0] <= self_ay_q[0];
      ax1_q[1] <= self_ax_q[1];
      ay1_q[1] <= self_ay_q[1];
      ax1_q[2] <= AXIS_WIDTH'(in_x[0]) - AXIS_WIDTH'(in_x[3]);
      ay1_q[2] <= AXIS_WIDTH'(in_y[0]) - AXIS_WIDTH'(in_y[3]);
      ax1_q[3] <= AXIS_WIDTH'(in_x[0]) - AXIS_WIDTH'(in_x[1]);
      ay1_q[3] <= AXIS_WIDTH'(in_y[0]) - AXIS_WIDTH'(in_y[1]);
    end
  end

  sat_span_t spans [NUM_LANES];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    sat_axis_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (pipe_ctrl),
      .ax_i    (ax1_q[i]),
      .ay_i    (ay1_q[i]),
      .self_x_i(s1_x_q),
      .self_y_i(s1_y_q),
      .tgt_x_i (t1_x_q),
      .tgt_y_i (t1_y_q),
      .span_o  (spans[i])
    );
  end

  sat_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en5),
    .spans_i  (spans),
    .overlap_o(overlap_o)
  );

  assign out_valid_o = vout_q;

endmodule

// ===== rtl/sat_axis_lane.sv =====
// One axis lane: projects all eight corners onto its axis and finds both intervals.
module sat_axis_lane import sat_pkg::*; (
  input  logic           clk_i,
  input  sat_pipe_ctrl_t ctrl_i,
  input  axis_t          ax_i,
  input  axis_t          ay_i,
  input  coord_t         self_x_i [NUM_CORNERS],
  input  coord_t         self_y_i [NUM_CORNERS],
  input  coord_t         tgt_x_i  [NUM_CORNERS],
  input  coord_t         tgt_y_i  [NUM_CORNERS],
  output sat_span_t      span_o
);

  function automatic sum_t min2(sum_t a, sum_t b);
    return (a <= b) ? a : b;
  endfunction

  function automatic sum_t max2(sum_t a, sum_t b);
    return (a >= b) ? a : b;
  endfunction

  coord_t    pts_x [NUM_POINTS];
  coord_t    pts_y [NUM_POINTS];
  prod_t     prod_x_q [NUM_POINTS];
  prod_t     prod_y_q [NUM_POINTS];
  sum_t      proj_q [NUM_POINTS];
  sat_span_t span_d, span_q;

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_pts
    assign pts_x[k]               = self_x_i[k];
    assign pts_y[k]               = self_y_i[k];
    assign pts_x[k + NUM_CORNERS] = tgt_x_i[k];
    assign pts_y[k + NUM_CORNERS] = tgt_y_i[k];
  end

  for (genvar k = 0; k < NUM_POINTS; k++) begin : g_proj
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en_prod) begin
        prod_x_q[k] <= PROD_WIDTH'(pts_x[k]) * PROD_WIDTH'(ax_i);
        prod_y_q[k] <= PROD_WIDTH'(pts_y[k]) * PROD_WIDTH'(ay_i);
      end
      if (ctrl_i.en_sum) begin
        proj_q[k] <= SUM_WIDTH'(prod_x_q[k]) + SUM_WIDTH'(prod_y_q[k]);
      end
    end
  end

  always_comb begin
    span_d.smin = min2(min2(proj_q[0], proj_q[1]), min2(proj_q[2], proj_q[3]));
    span_d.smax = max2(max2(proj_q[0], proj_q[1]), max2(proj_q[2], proj_q[3]));
    span_d.tmin = min2(min2(proj_q[4], proj_q[5]), min2(proj_q[6], proj_q[7]));
    span_d.tmax = max2(max2(proj_q[4], proj_q[5]), max2(proj_q[6], proj_q[7]));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_span) begin
      span_q <= span_d;
    end
  end

  assign span_o = span_q;

endmodule

// ===== rtl/sat_merge.sv =====
// Merge stage: the shapes overlap only if the intervals meet on every axis.
module sat_merge import sat_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  sat_span_t spans_i [NUM_LANES],
  output logic      overlap_o
);

  logic [NUM_LANES-1:0] lane_ok;
  logic                 overlap_d, overlap_q;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      // Touching intervals count as meeting.
      lane_ok[i] = (spans_i[i].tmin <= spans_i[i].smax) &&
                   (spans_i[i].smin <= spans_i[i].tmax);
    end
    overlap_d = &lane_ok;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      overlap_q <= overlap_d;
    end
  end

  assign overlap_o = overlap_q;

endmodule

// ===== rtl/sat_checker.sv =====
// Port-level checks for the rectangle separating-axis test, bound to the top level.
module sat_checker import sat_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic role_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic overlap_o
);

  logic tgt_xfer;
  assign tgt_xfer = in_valid_i && !in_stall_o && (role_i == ROLE_TARGET);

  // A held result keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(overlap_o))
    else $error("stalled result changed");

  // With an empty output register nothing can back up into the input.
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result present right after reset");

  // A target transfer with a free-running output reaches the output as a valid result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(tgt_xfer, 5) && $past(rst_ni, 5) && $past(rst_ni, 4) && $past(rst_ni, 3) &&
    $past(rst_ni, 2) && $past(rst_ni, 1) && !$past(out_stall_i, 4) &&
    !$past(out_stall_i, 3) && !$past(out_stall_i, 2) && !$past(out_stall_i, 1)
    |-> out_valid_o)
    else $error("target result missing after pipeline latency");

endmodule

bind rect_separating_axis_test sat_checker u_sat_checker (.*);
